FILE: rtl/mfa_pkg.sv
`timescale 1ns / 1ps

package mfa_pkg;

    localparam int OP_W       = 3;
    localparam int IDX_RAW_W  = 12;
    localparam int SAMPLE_W   = 32;
    localparam int ACC_W      = 48;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PTR_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_SUM    = 3'd0,
        OP_WSUM   = 3'd1,
        OP_SUMSQ  = 3'd2,
        OP_WSUMSQ = 3'd3,
        OP_MIN    = 3'd4,
        OP_MAX    = 3'd5,
        OP_COUNT  = 3'd6,
        OP_RUNLEN = 3'd7
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_VALUE = 1'b1;

    localparam logic [SAMPLE_W-1:0] WEIGHT_RESET = 32'h0001_0000;
    localparam logic [SAMPLE_W-1:0] REF_RESET    = 32'h0000_0000;

    localparam logic [ACC_W-1:0] ACC_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [ACC_W-1:0] ACC_MIN = 48'h8000_0000_0000;
    localparam logic [ACC_W-1:0] ONE_Q16 = 48'h0000_0001_0000;
    localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

    typedef struct packed {
        logic [ACC_W-1:0] new_value;
        logic             value_missing;
        logic [CNT_W-1:0] miss_count;
    } t_result;

endpackage

FILE: rtl/mfa_acc_ram.sv
`timescale 1ns / 1ps

module mfa_acc_ram #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 49
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mfa_out_queue.sv
`timescale 1ns / 1ps

module mfa_out_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfa_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output mfa_pkg::t_result o_data
);

    localparam int PTR_W = mfa_pkg::OUTQ_PTR_W;

    mfa_pkg::t_result r_buf [mfa_pkg::OUTQ_DEPTH];
    logic [PTR_W:0]   r_wptr;
    logic [PTR_W:0]   r_rptr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr[PTR_W-1:0]] <= i_data;
        end
    end

    assign o_valid = (r_wptr != r_rptr);
    assign o_data  = r_buf[r_rptr[PTR_W-1:0]];

endmodule

FILE: rtl/masked_field_accumulator_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_op, i_point_index, i_sample,
//                                         i_sample_missing, i_last_point
// result    out        o_valid / i_stall  o_new_value, o_value_missing, o_miss_count
// config    in         i_cfg_wr_en        i_cfg_index, i_cfg_wr_data
//
// One word is accepted per cycle while o_stall is low; its result is queued in stage 4.
// The accumulator memory is read in stage 2 and written in stage 4; results still in
// flight for the same grid point are forwarded, so repeated points run at full rate.
// After reset a clearing pass marks every entry missing while o_stall is held high.
// The output queue holds eight words; o_stall rises once eight words are in flight.

module masked_field_accumulator_core #(
    parameter int GRID_POINTS = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [mfa_pkg::OP_W-1:0]             i_op,
    input  logic [mfa_pkg::IDX_RAW_W-1:0]        i_point_index,
    input  logic signed [mfa_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                                 i_sample_missing,
    input  logic                                 i_last_point,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [mfa_pkg::ACC_W-1:0]     o_new_value,
    output logic                                 o_value_missing,
    output logic [mfa_pkg::CNT_W-1:0]            o_miss_count,
    input  logic                                 i_cfg_wr_en,
    input  logic [mfa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mfa_pkg::CFG_DATA_W-1:0]       i_cfg_wr_data
);

    localparam int IDX_W  = (GRID_POINTS > 1) ? $clog2(GRID_POINTS) : 1;
    localparam int ACC_W  = mfa_pkg::ACC_W;
    localparam int SW     = mfa_pkg::SAMPLE_W;
    localparam int RAW_W  = mfa_pkg::IDX_RAW_W;
    localparam int WORD_W = ACC_W + 1;
    localparam int INF_W  = $clog2(mfa_pkg::OUTQ_DEPTH + 1);

    function automatic logic [SW-1:0] f_mag32(input logic [SW-1:0] v);
        f_mag32 = v[SW-1] ? SW'(0 - v) : v;
    endfunction

    logic [SW-1:0] r_weight;
    logic [SW-1:0] r_ref_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight    <= mfa_pkg::WEIGHT_RESET;
            r_ref_value <= mfa_pkg::REF_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mfa_pkg::CFG_WEIGHT:    r_weight    <= i_cfg_wr_data;
                mfa_pkg::CFG_REF_VALUE: r_ref_value <= i_cfg_wr_data;
                default:                r_weight    <= r_weight;
            endcase
        end
    end

    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic [INF_W-1:0] r_inflight;
    logic             w_accept;
    logic             w_pop;

    assign o_stall  = r_clr_busy || (r_inflight == INF_W'(mfa_pkg::OUTQ_DEPTH));
    assign w_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == IDX_W'(GRID_POINTS - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + INF_W'(w_accept) - INF_W'(w_pop);
        end
    end

    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // Stage 1: magnitude products.
    mfa_pkg::t_op r1_op;
    logic [RAW_W-1:0] r1_idx_raw;
    logic [SW-1:0]    r1_s;
    logic             r1_smiss;
    logic             r1_last;
    logic [SW-1:0]    w_mag_s;
    logic [SW-1:0]    w_mag_w;
    logic [63:0]      w_sw;
    logic [63:0]      w_ss;

    always_ff @(posedge i_clk) begin
        r1_op      <= mfa_pkg::t_op'(i_op);
        r1_idx_raw <= i_point_index;
        r1_s       <= i_sample;
        r1_smiss   <= i_sample_missing;
        r1_last    <= i_last_point;
    end

    assign w_mag_s = f_mag32(r1_s);
    assign w_mag_w = f_mag32(r_weight);
    assign w_sw    = 64'(w_mag_s) * 64'(w_mag_w);
    assign w_ss    = 64'(w_mag_s) * 64'(w_mag_s);

    // Stage 2: index reduction, memory read, weighted square partial products.
    mfa_pkg::t_op r2_op;
    logic [RAW_W-1:0] r2_idx_raw;
    logic [SW-1:0]    r2_s;
    logic             r2_smiss;
    logic             r2_last;
    logic [63:0]      r2_sw;
    logic [63:0]      r2_ss;
    logic             r2_neg_sw;
    logic [IDX_W-1:0] w_idx2;
    logic [63:0]      w_wlo;
    logic [63:0]      w_whi;

    always_ff @(posedge i_clk) begin
        r2_op      <= r1_op;
        r2_idx_raw <= r1_idx_raw;
        r2_s       <= r1_s;
        r2_smiss   <= r1_smiss;
        r2_last    <= r1_last;
        r2_sw      <= w_sw;
        r2_ss      <= w_ss;
        r2_neg_sw  <= r1_s[SW-1] ^ r_weight[SW-1];
    end

    generate
        if (GRID_POINTS >= (1 << RAW_W)) begin : g_idx_wide
            assign w_idx2 = IDX_W'(r2_idx_raw);
        end else begin : g_idx_mod
            localparam int         RSH    = 26;
            localparam logic [26:0] RECIP = 27'(((1 << RSH) + GRID_POINTS - 1) / GRID_POINTS);
            localparam logic [RAW_W-1:0] GRID_N = RAW_W'(GRID_POINTS);
            logic [38:0]      w_qprod;
            logic [RAW_W-1:0] r2_q;
            logic [23:0]      w_qg;

            assign w_qprod = 39'(r1_idx_raw) * 39'(RECIP);

            always_ff @(posedge i_clk) begin
                r2_q <= w_qprod[RSH+RAW_W-1:RSH];
            end

            assign w_qg   = 24'(r2_q) * 24'(GRID_N);
            assign w_idx2 = IDX_W'(r2_idx_raw - w_qg[RAW_W-1:0]);
        end
    endgenerate

    assign w_wlo = 64'(r2_ss[31:0]) * 64'(w_mag_w);
    assign w_whi = 64'(r2_ss[63:32]) * 64'(w_mag_w);

    // Stage 3: rounding and saturation of the term, forwarding of the entry.
    mfa_pkg::t_op r3_op;
    logic [IDX_W-1:0] r3_idx;
    logic [SW-1:0]    r3_s;
    logic             r3_smiss;
    logic             r3_last;
    logic [63:0]      r3_sw;
    logic [63:0]      r3_ss;
    logic             r3_neg_sw;
    logic [63:0]      r3_wlo;
    logic [63:0]      r3_whi;
    logic [WORD_W-1:0] w_rdata;

    always_ff @(posedge i_clk) begin
        r3_op     <= r2_op;
        r3_idx    <= w_idx2;
        r3_s      <= r2_s;
        r3_smiss  <= r2_smiss;
        r3_last   <= r2_last;
        r3_sw     <= r2_sw;
        r3_ss     <= r2_ss;
        r3_neg_sw <= r2_neg_sw;
        r3_wlo    <= w_wlo;
        r3_whi    <= w_whi;
    end

    logic [63:0]       w_sw_rnd;
    logic [63:0]       w_ss_rnd;
    logic [64:0]       w_lo_rnd;
    logic [63:0]       w_wsq;
    logic [ACC_W-1:0]  w_sw_term;
    logic [ACC_W-1:0]  w_wsq_term;
    logic [ACC_W-1:0]  w_s48_3;
    logic [ACC_W-1:0]  w_term3;
    logic [WORD_W-1:0] w_fwd;
    logic [WORD_W-1:0] w_wr_word;
    logic [IDX_W-1:0]  r5_idx;
    logic [WORD_W-1:0] r5_word;

    mfa_pkg::t_op r4_op;
    logic [IDX_W-1:0] r4_idx;
    logic [SW-1:0]    r4_s;
    logic             r4_smiss;
    logic             r4_last;
    logic [ACC_W-1:0] r4_term;
    logic [ACC_W-1:0] r4_acc;
    logic             r4_val;

    localparam logic [63:0] LIM_POS = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] LIM_NEG = 64'h0000_8000_0000_0000;

    assign w_sw_rnd = r3_sw + 64'h8000;
    assign w_ss_rnd = r3_ss + 64'h8000;
    assign w_lo_rnd = 65'(r3_wlo) + 65'h8000_0000;
    assign w_wsq    = r3_whi + 64'(w_lo_rnd[64:32]);
    assign w_s48_3  = {{(ACC_W-SW){r3_s[SW-1]}}, r3_s};

    assign w_sw_term = r3_neg_sw ? ACC_W'(64'd0 - {16'd0, w_sw_rnd[63:16]})
                                 : w_sw_rnd[63:16];

    always_comb begin
        if (r_weight[SW-1]) begin
            w_wsq_term = (w_wsq >= LIM_NEG) ? mfa_pkg::ACC_MIN : ACC_W'(64'd0 - w_wsq);
        end else begin
            w_wsq_term = (w_wsq > LIM_POS) ? mfa_pkg::ACC_MAX : w_wsq[ACC_W-1:0];
        end
    end

    always_comb begin
        unique case (r3_op)
            mfa_pkg::OP_WSUM:   w_term3 = w_sw_term;
            mfa_pkg::OP_SUMSQ:  w_term3 = w_ss_rnd[63:16];
            mfa_pkg::OP_WSUMSQ: w_term3 = w_wsq_term;
            mfa_pkg::OP_COUNT:  w_term3 = mfa_pkg::ONE_Q16;
            mfa_pkg::OP_SUM,
            mfa_pkg::OP_MIN,
            mfa_pkg::OP_MAX,
            mfa_pkg::OP_RUNLEN: w_term3 = w_s48_3;
            default:            w_term3 = w_s48_3;
        endcase
    end

    always_comb begin
        priority if (r_v4 && (r4_idx == r3_idx)) begin
            w_fwd = w_wr_word;
        end else if (r_v5 && (r5_idx == r3_idx)) begin
            w_fwd = r5_word;
        end else begin
            w_fwd = w_rdata;
        end
    end

    // Stage 4: accumulate and write back.
    always_ff @(posedge i_clk) begin
        r4_op    <= r3_op;
        r4_idx   <= r3_idx;
        r4_s     <= r3_s;
        r4_smiss <= r3_smiss;
        r4_last  <= r3_last;
        r4_term  <= w_term3;
        r4_acc   <= w_fwd[ACC_W-1:0];
        r4_val   <= w_fwd[ACC_W];
    end

    logic [ACC_W-1:0]         w_acc4;
    logic [ACC_W-1:0]         w_addend;
    logic [ACC_W:0]           w_sum;
    logic [ACC_W-1:0]         w_sat;
    logic [ACC_W-1:0]         w_s48_4;
    logic                     w_eq;
    logic                     w_nv;
    logic [ACC_W-1:0]         w_nacc;
    logic [mfa_pkg::CNT_W-1:0] r_miss_cnt;
    logic [mfa_pkg::CNT_W-1:0] w_cnt_inc;
    mfa_pkg::t_result         w_result;
    mfa_pkg::t_result         w_q_data;

    assign w_acc4   = r4_val ? r4_acc : '0;
    assign w_addend = (r4_op == mfa_pkg::OP_RUNLEN) ? mfa_pkg::ONE_Q16 : r4_term;
    assign w_sum    = {w_acc4[ACC_W-1], w_acc4} + {w_addend[ACC_W-1], w_addend};
    assign w_sat    = (w_sum[ACC_W] != w_sum[ACC_W-1])
                    ? (w_sum[ACC_W] ? mfa_pkg::ACC_MIN : mfa_pkg::ACC_MAX)
                    : w_sum[ACC_W-1:0];
    assign w_s48_4  = {{(ACC_W-SW){r4_s[SW-1]}}, r4_s};
    assign w_eq     = (r4_s == r_ref_value);

    always_comb begin
        w_nv   = r4_val;
        w_nacc = w_acc4;
        priority if (r4_op == mfa_pkg::OP_RUNLEN) begin
            if (r4_smiss) begin
                w_nacc = '0;
            end else if (w_eq) begin
                w_nv   = 1'b1;
                w_nacc = '0;
            end else begin
                w_nv   = 1'b1;
                w_nacc = r4_val ? w_sat : mfa_pkg::ONE_Q16;
            end
        end else if (!r4_smiss) begin
            w_nv = 1'b1;
            if (!r4_val) begin
                w_nacc = r4_term;
            end else if (r4_op == mfa_pkg::OP_MIN) begin
                w_nacc = ($signed(w_s48_4) < $signed(w_acc4)) ? w_s48_4 : w_acc4;
            end else if (r4_op == mfa_pkg::OP_MAX) begin
                w_nacc = ($signed(w_s48_4) > $signed(w_acc4)) ? w_s48_4 : w_acc4;
            end else begin
                w_nacc = w_sat;
            end
        end else begin
            w_nv   = r4_val;
            w_nacc = w_acc4;
        end
    end

    assign w_wr_word = {w_nv, w_nacc};
    assign w_cnt_inc = (!w_nv && (r_miss_cnt < mfa_pkg::CNT_MAX)) ? r_miss_cnt + 1'b1
                                                                 : r_miss_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_cnt <= '0;
        end else if (r_v4) begin
            r_miss_cnt <= r4_last ? '0 : w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_idx  <= r4_idx;
        r5_word <= w_wr_word;
    end

    assign w_result.new_value     = w_nv ? w_nacc : '0;
    assign w_result.value_missing = !w_nv;
    assign w_result.miss_count    = w_cnt_inc;

    mfa_acc_ram #(
        .DEPTH  (GRID_POINTS),
        .ADDR_W (IDX_W),
        .DATA_W (WORD_W)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_clr_busy || r_v4),
        .i_waddr (r_clr_busy ? r_clr_addr : r4_idx),
        .i_wdata (r_clr_busy ? '0 : w_wr_word),
        .i_raddr (w_idx2),
        .o_rdata (w_rdata)
    );

    mfa_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_v4),
        .i_data  (w_result),
        .i_pop   (w_pop),
        .o_valid (o_valid),
        .o_data  (w_q_data)
    );

    assign w_pop           = o_valid && !i_stall;
    assign o_new_value     = w_q_data.new_value;
    assign o_value_missing = w_q_data.value_missing;
    assign o_miss_count    = w_q_data.miss_count;

endmodule

FILE: verif/masked_field_accumulator_core_tb.sv
`timescale 1ns / 1ps

module masked_field_accumulator_core_tb;

    localparam int GRID     = 4096;
    localparam int ACC_W    = mfa_pkg::ACC_W;
    localparam int CNT_W    = mfa_pkg::CNT_W;
    localparam int SAMPLE_W = mfa_pkg::SAMPLE_W;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    mfa_pkg::t_op                         i_op = mfa_pkg::OP_SUM;
    logic [mfa_pkg::IDX_RAW_W-1:0]        i_point_index = '0;
    logic signed [SAMPLE_W-1:0]           i_sample = '0;
    logic                                 i_sample_missing = 1'b0;
    logic                                 i_last_point = 1'b0;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic signed [ACC_W-1:0]              o_new_value;
    logic                                 o_value_missing;
    logic [CNT_W-1:0]                     o_miss_count;
    logic                                 i_cfg_wr_en = 1'b0;
    logic [mfa_pkg::CFG_IDX_W-1:0]        i_cfg_index = mfa_pkg::CFG_WEIGHT;
    logic [mfa_pkg::CFG_DATA_W-1:0]       i_cfg_wr_data = '0;

    logic signed [ACC_W-1:0] acc_model [GRID];
    bit                      valid_model [GRID];
    logic [CNT_W-1:0]        miss_model = '0;
    logic [SAMPLE_W-1:0]     weight_model = mfa_pkg::WEIGHT_RESET;
    logic [SAMPLE_W-1:0]     ref_model = mfa_pkg::REF_RESET;

    mfa_pkg::t_result pending_updates [$];
    int               mismatch_count = 0;
    bit               quiet = 1'b0;
    int               rx_hold = 0;

    masked_field_accumulator_core #(
        .GRID_POINTS(GRID)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_op            (i_op),
        .i_point_index   (i_point_index),
        .i_sample        (i_sample),
        .i_sample_missing(i_sample_missing),
        .i_last_point    (i_last_point),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_new_value     (o_new_value),
        .o_value_missing (o_value_missing),
        .o_miss_count    (o_miss_count),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic signed [ACC_W-1:0] add_clip(logic signed [ACC_W-1:0] a,
                                                        logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        s = a + b;
        if (s[ACC_W] != s[ACC_W-1]) return s[ACC_W] ? mfa_pkg::ACC_MIN : mfa_pkg::ACC_MAX;
        return s[ACC_W-1:0];
    endfunction

    // Rounds a product magnitude to nearest with ties away from zero, then clips.
    function automatic logic signed [ACC_W-1:0] round_product(bit neg, logic [95:0] mag,
                                                             int shift);
        logic [95:0] r;
        r = (mag + (96'd1 << (shift - 1))) >> shift;
        if (!neg && r > {48'd0, mfa_pkg::ACC_MAX}) r = {48'd0, mfa_pkg::ACC_MAX};
        if (neg && r > {48'd0, mfa_pkg::ACC_MIN}) r = {48'd0, mfa_pkg::ACC_MIN};
        return neg ? -r[ACC_W-1:0] : r[ACC_W-1:0];
    endfunction

    function automatic mfa_pkg::t_result accumulate_point(mfa_pkg::t_op op,
                                                          logic [11:0] point,
                                                          logic [31:0] smp, bit missing,
                                                          bit last);
        mfa_pkg::t_result        res;
        logic signed [ACC_W-1:0] s48;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] term;
        logic [63:0]             sq;
        bit                      is_valid;
        s48 = {{16{smp[31]}}, smp};
        is_valid = valid_model[point];
        acc = is_valid ? acc_model[point] : '0;
        term = '0;
        if (op == mfa_pkg::OP_RUNLEN) begin
            if (missing) begin
                if (is_valid) acc = '0;
            end else if (smp == ref_model) begin
                acc = '0;
                is_valid = 1'b1;
            end else begin
                acc = is_valid ? add_clip(acc, mfa_pkg::ONE_Q16) : mfa_pkg::ONE_Q16;
                is_valid = 1'b1;
            end
        end else if (!missing) begin
            sq = 64'(mag32(smp)) * 64'(mag32(smp));
            case (op)
                mfa_pkg::OP_WSUM: term = round_product(smp[31] ^ weight_model[31],
                                                       96'(mag32(smp)) *
                                                       96'(mag32(weight_model)), 16);
                mfa_pkg::OP_SUMSQ: term = round_product(1'b0, 96'(sq), 16);
                mfa_pkg::OP_WSUMSQ: term = round_product(weight_model[31],
                                                         96'(sq) * 96'(mag32(weight_model)),
                                                         32);
                mfa_pkg::OP_COUNT: term = mfa_pkg::ONE_Q16;
                default: term = s48;
            endcase
            if (!is_valid) acc = term;
            else if (op == mfa_pkg::OP_MIN) acc = (s48 < acc) ? s48 : acc;
            else if (op == mfa_pkg::OP_MAX) acc = (s48 > acc) ? s48 : acc;
            else acc = add_clip(acc, term);
            is_valid = 1'b1;
        end
        valid_model[point] = is_valid;
        if (is_valid) acc_model[point] = acc;
        if (!is_valid && miss_model != mfa_pkg::CNT_MAX) miss_model++;
        res.new_value = is_valid ? acc : '0;
        res.value_missing = !is_valid;
        res.miss_count = miss_model;
        if (last) miss_model = '0;
        return res;
    endfunction

    task automatic send_word(input mfa_pkg::t_op op, input logic [11:0] point,
                             input logic [31:0] smp, input bit missing, input bit last);
        int gap;
        gap = gap_len();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        i_point_index <= point;
        i_sample <= smp;
        i_sample_missing <= missing;
        i_last_point <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_updates.push_back(accumulate_point(op, point, smp, missing, last));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_updates.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mfa_pkg::CFG_IDX_W-1:0] index,
                             input logic [31:0] data);
        drain_results();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wr_data <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (index == mfa_pkg::CFG_WEIGHT) weight_model = data;
        else ref_model = data;
    endtask

    task report_mismatch(input string field, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch in %s: got %h, expected %h", field, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(0, 3) == 0);
            rx_hold <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        mfa_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_updates.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_new_value), 64'd0);
            end else begin
                want = pending_updates.pop_front();
                if (o_new_value !== want.new_value)
                    report_mismatch("new_value", 64'(o_new_value), 64'(want.new_value));
                if (o_value_missing !== want.value_missing)
                    report_mismatch("value_missing", 64'(o_value_missing),
                                    64'(want.value_missing));
                if (o_miss_count !== want.miss_count)
                    report_mismatch("miss_count", 64'(o_miss_count), 64'(want.miss_count));
            end
        end
    end

    task automatic test_directed_ops();
        send_word(mfa_pkg::OP_SUM, 12'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_SUM, 12'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_SUM, 12'd0, 32'h0000_0000, 1'b1, 1'b0);
        send_word(mfa_pkg::OP_SUM, 12'hFFF, 32'h8000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_SUM, 12'd1, 32'h1234_5678, 1'b1, 1'b0);
        send_word(mfa_pkg::OP_WSUM, 12'd2, 32'h0001_8000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_SUMSQ, 12'd3, 32'hFFFF_8000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_SUMSQ, 12'd3, 32'h8000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_WSUMSQ, 12'd4, 32'h0002_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_MIN, 12'd5, 32'h0000_0005, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_MIN, 12'd5, 32'hFFFF_FFFD, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_MAX, 12'd6, 32'hFFFF_FFF9, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_MAX, 12'd6, 32'h0000_0064, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_COUNT, 12'd7, 32'hDEAD_BEEF, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_COUNT, 12'd7, 32'h0000_0001, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_COUNT, 12'd7, 32'h0000_0001, 1'b1, 1'b0);
        send_word(mfa_pkg::OP_RUNLEN, 12'd8, 32'h0001_0000, 1'b1, 1'b0);
        send_word(mfa_pkg::OP_RUNLEN, 12'd8, 32'h0000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_RUNLEN, 12'd8, 32'h0001_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_RUNLEN, 12'd8, 32'h0001_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_RUNLEN, 12'd8, 32'h0000_0000, 1'b1, 1'b1);
        drain_results();
    endtask

    task automatic test_weight_and_reference();
        write_reg(mfa_pkg::CFG_WEIGHT, 32'h0000_8000);
        send_word(mfa_pkg::OP_WSUM, 12'd20, 32'h0000_0001, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_WSUM, 12'd21, 32'hFFFF_FFFF, 1'b0, 1'b0);
        write_reg(mfa_pkg::CFG_WEIGHT, 32'h8000_0000);
        send_word(mfa_pkg::OP_WSUMSQ, 12'd22, 32'h8000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_WSUMSQ, 12'd22, 32'h8000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_MIN, 12'd22, 32'h0000_0005, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_WSUM, 12'd23, 32'h8000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_WSUM, 12'd23, 32'h8000_0000, 1'b0, 1'b0);
        write_reg(mfa_pkg::CFG_WEIGHT, 32'h7FFF_FFFF);
        send_word(mfa_pkg::OP_WSUMSQ, 12'd24, 32'h8000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_SUM, 12'd24, 32'h7FFF_FFFF, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_RUNLEN, 12'd24, 32'h0000_0001, 1'b0, 1'b0);
        write_reg(mfa_pkg::CFG_WEIGHT, 32'h0000_0000);
        send_word(mfa_pkg::OP_WSUM, 12'd25, 32'h7FFF_FFFF, 1'b0, 1'b0);
        write_reg(mfa_pkg::CFG_REF_VALUE, 32'h8000_0000);
        send_word(mfa_pkg::OP_RUNLEN, 12'd26, 32'h8000_0000, 1'b0, 1'b0);
        send_word(mfa_pkg::OP_RUNLEN, 12'd26, 32'h7FFF_FFFF, 1'b0, 1'b0);
        write_reg(mfa_pkg::CFG_REF_VALUE, 32'h7FFF_FFFF);
        send_word(mfa_pkg::OP_RUNLEN, 12'd26, 32'h7FFF_FFFF, 1'b0, 1'b1);
        drain_results();
    endtask

    // Points from 2048 to 4094 are still missing here, so every word raises the pass count.
    task automatic test_pass_counter();
        quiet = 1'b1;
        repeat (150) begin
            send_word(mfa_pkg::t_op'($urandom_range(0, 7)), 12'($urandom_range(2048, 4094)),
                      $urandom, 1'b1, 1'b0);
        end
        send_word(mfa_pkg::OP_SUM, 12'($urandom_range(2048, 4094)), $urandom, 1'b1, 1'b1);
        drain_results();
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        logic [11:0] hot_points [16];
        logic [11:0] point;
        logic [31:0] smp;
        int          r;
        foreach (hot_points[k]) hot_points[k] = 12'($urandom);
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(mfa_pkg::CFG_WEIGHT, mfa_pkg::WEIGHT_RESET);
                    write_reg(mfa_pkg::CFG_REF_VALUE, mfa_pkg::REF_RESET);
                end
                1: begin
                    write_reg(mfa_pkg::CFG_WEIGHT, $urandom);
                    write_reg(mfa_pkg::CFG_REF_VALUE, $urandom);
                end
                2: begin
                    write_reg(mfa_pkg::CFG_WEIGHT, 32'hFFFF_0000);
                    write_reg(mfa_pkg::CFG_REF_VALUE, 32'($urandom_range(0, 32'h3_FFFF)));
                end
                3: begin
                    write_reg(mfa_pkg::CFG_WEIGHT,
                              $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h3_FFFF))
                                                   : -32'($urandom_range(0, 32'h3_FFFF)));
                    write_reg(mfa_pkg::CFG_REF_VALUE, 32'h7FFF_FFFF);
                end
                default: begin
                    write_reg(mfa_pkg::CFG_WEIGHT, 32'h7FFF_FFFF);
                    write_reg(mfa_pkg::CFG_REF_VALUE, 32'hFFFF_FFFF);
                end
            endcase
            quiet = (phase == 1);
            for (int i = 0; i < 210; i++) begin
                if (phase == 3 && i == 105) drain_results();
                r = $urandom_range(0, 99);
                if (r < 5) hot_points[$urandom_range(0, 15)] = 12'($urandom);
                if (r < 75) point = hot_points[$urandom_range(0, 15)];
                else point = 12'($urandom);
                case ($urandom_range(0, 9))
                    0: smp = ref_model;
                    1: begin
                        case ($urandom_range(0, 3))
                            0: smp = 32'h7FFF_FFFF;
                            1: smp = 32'h8000_0000;
                            2: smp = 32'h0000_0000;
                            default: smp = 32'hFFFF_FFFF;
                        endcase
                    end
                    2, 3, 4: begin
                        smp = $urandom_range(0, 32'h3_FFFF);
                        if ($urandom_range(0, 1) == 1) smp = -smp;
                    end
                    default: smp = $urandom;
                endcase
                send_word(mfa_pkg::t_op'($urandom_range(0, 7)), point, smp,
                          $urandom_range(0, 4) == 0, $urandom_range(0, 24) == 0);
            end
            drain_results();
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_weight_and_reference();
        test_pass_counter();
        test_random_traffic();
        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
